// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the encoder RTL.
// ASSERT_PROP checks a property on every rising clock edge outside reset.
// ASSERT_NEVER checks that an expression is never true outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);
`define ASSERT_NEVER(label, clk_sig, rst_sig, expr, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(label, clk_sig, rst_sig, prop, msg)
`define ASSERT_NEVER(label, clk_sig, rst_sig, expr, msg)
`endif

`endif

// ===== rtl/core/rle_pkg.sv =====
package rle_pkg;

  // Item kinds on the input channel.
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // Encoded symbols.
  localparam logic [7:0] RLE_MARK   = 8'h21;  // '!'
  localparam logic [7:0] RLE_DIGIT0 = 8'h30;  // '0'

  // A run closes by itself when its count (length minus one) reaches this.
  localparam logic [3:0] CLOSE_COUNT = 4'd9;

  // Most bytes one item can cause.
  localparam int unsigned MAX_BURST = 3;

  // Default output queue address width (depth 8).
  localparam int unsigned QUEUE_AW_DEFAULT = 3;

  // Bytes produced by one item, in order; count says how many are real.
  typedef struct packed {
    logic [1:0] count;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } burst_t;

endpackage

// ===== rtl/core/rle_in_if.sv =====
interface rle_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data;

  modport source (output valid, output kind, output data, input ready);
  modport sink   (input valid, input kind, input data, output ready);
endinterface

// ===== rtl/core/rle_out_if.sv =====
interface rle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// ===== rtl/core/rle_queue.sv =====
`include "assert_macros.svh"

// Output queue: takes up to three bytes per cycle, hands out one while the reader is ready.
module rle_queue
  import rle_pkg::*;
#(
  parameter int unsigned Aw = QUEUE_AW_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  burst_t push,
  output logic room,
  rle_out_if.source coded
);

  localparam int unsigned Depth = 1 << Aw;
  localparam int unsigned Fw    = Aw + 1;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } entry_t;

  entry_t        mem [Depth];
  logic [Aw-1:0] head;
  logic [Aw-1:0] tail;
  logic [Fw-1:0] fill;
  logic [Fw-1:0] fill_next;
  logic          pop;

  logic [Aw-1:0] w_idx   [MAX_BURST];
  entry_t        w_entry [MAX_BURST];

  assign pop = coded.valid && coded.ready;

  always_comb begin
    for (int i = 0; i < MAX_BURST; i++) begin
      w_idx[i] = tail + Aw'(i);
    end
    w_entry[0] = '{b: push.b0, last: (push.count == 2'd1)};
    w_entry[1] = '{b: push.b1, last: (push.count == 2'd2)};
    w_entry[2] = '{b: push.b2, last: (push.count == 2'd3)};
    fill_next  = fill + Fw'(push.count) - Fw'(pop);
  end

  // Room for a full burst; a pop in the same cycle is not counted.
  assign room = (Fw'(Depth) - fill) >= Fw'(MAX_BURST);

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      if (pop) begin
        head <= head + Aw'(1);
      end
      tail <= tail + Aw'(push.count);
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_BURST; i++) begin
      if (2'(i) < push.count) begin
        mem[w_idx[i]] <= w_entry[i];
      end
    end
  end

  assign coded.valid    = (fill != '0);
  assign coded.out_byte = mem[head].b;
  assign coded.last     = mem[head].last;

  `ASSERT_NEVER(a_fill_bound, clk, rst, fill > Fw'(Depth), "queue fill exceeds depth")
  `ASSERT_PROP(a_push_has_room, clk, rst, push.count != 2'd0 |-> room, "push without room")
  `ASSERT_NEVER(a_ptr_gap, clk, rst, (tail - head) != fill[Aw-1:0], "pointers disagree with fill")

endmodule

// ===== rtl/core/run_length_encoder_core.sv =====
// Run-length encoder for a byte stream. Each input item is a data byte or an
// end-of-stream marker. A run of one byte comes out as the byte, a run of two
// as the byte twice, and a run of three to ten as the byte, '!' and the ASCII
// digit of the run length minus one; a run that reaches ten bytes closes on
// its own. End of stream flushes any pending run (a lone byte included) and
// clears the state. The last byte caused by an item carries last = 1; an item
// that only extends a run causes no bytes. Throughput: one item per cycle
// while the queue has room, from the combinational encode step. Result
// bytes leave at one per cycle while the consumer is ready, from a 2**QueueAw
// entry queue; the input is ready whenever that queue has room for three
// bytes, so a run of items that each emit more than one byte back-pressures
// once it fills. An item's bytes are queued on accept, behind earlier bytes.
`include "assert_macros.svh"

module run_length_encoder_core
  import rle_pkg::*;
#(
  parameter int unsigned QueueAw = QUEUE_AW_DEFAULT  // queue depth 2**QueueAw, at least 2
) (
  input  logic clk,
  input  logic rst,
  rle_in_if.sink    raw,
  rle_out_if.source coded
);

  // Pending run.
  logic [7:0] held_byte;
  logic [7:0] held_byte_next;
  logic       held_valid;
  logic       held_valid_next;
  logic [3:0] repeat_count;       // run length minus one
  logic [3:0] repeat_count_next;

  logic       accept;
  logic       room;
  logic [3:0] count_inc;
  burst_t     burst;

  // Bytes that close a run of length c + 1.
  function automatic burst_t run_burst(input logic [7:0] b, input logic [3:0] c);
    burst_t r;
    r    = '0;
    r.b0 = b;
    if (c >= 4'd2) begin
      r.count = 2'd3;
      r.b1    = RLE_MARK;
      r.b2    = RLE_DIGIT0 + {4'b0000, c};
    end else if (c == 4'd1) begin
      r.count = 2'd2;
      r.b1    = b;
    end else begin
      r.count = 2'd1;
    end
    return r;
  endfunction

  assign raw.ready = room;
  assign accept    = raw.valid && raw.ready;
  assign count_inc = repeat_count + 4'd1;

  always_comb begin
    held_byte_next    = held_byte;
    held_valid_next   = held_valid;
    repeat_count_next = repeat_count;
    burst             = '0;
    if (accept) begin
      if (raw.kind == KIND_FLUSH) begin
        // End of stream: drain whatever is held, then start clean.
        if (held_valid) begin
          burst = run_burst(held_byte, repeat_count);
        end
        held_byte_next    = '0;
        held_valid_next   = 1'b0;
        repeat_count_next = '0;
      end else if (held_valid && (raw.data == held_byte)) begin
        if (count_inc >= CLOSE_COUNT) begin
          // Tenth byte of a run: emit it now, hold nothing.
          burst             = run_burst(held_byte, count_inc);
          held_byte_next    = '0;
          held_valid_next   = 1'b0;
          repeat_count_next = '0;
        end else begin
          repeat_count_next = count_inc;
        end
      end else begin
        // New byte value: close the old run and start a new one.
        if (held_valid) begin
          burst = run_burst(held_byte, repeat_count);
        end
        held_byte_next    = raw.data;
        held_valid_next   = 1'b1;
        repeat_count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte    <= '0;
      held_valid   <= 1'b0;
      repeat_count <= '0;
    end else begin
      held_byte    <= held_byte_next;
      held_valid   <= held_valid_next;
      repeat_count <= repeat_count_next;
    end
  end

  rle_queue #(
    .Aw (QueueAw)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (burst),
    .room  (room),
    .coded (coded)
  );

  `ASSERT_NEVER(a_count_below_close, clk, rst, repeat_count >= CLOSE_COUNT, "run count reached close")
  `ASSERT_NEVER(a_idle_count_zero, clk, rst, !held_valid && repeat_count != 4'd0, "count without run")
  `ASSERT_PROP(a_flush_clears, clk, rst, accept && raw.kind == KIND_FLUSH |=> !held_valid, "flush left a run")

endmodule
